### design/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, constants and character tables of the label character decoder.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int MAX_LABEL_LEN = 1024;
  localparam int CodeW   = 8;
  localparam int CntW    = 10;
  localparam int MaxLenW = 11;
  localparam int LimW    = $clog2(MAX_LABEL_LEN);
  localparam int CfgIdxW = 2;

  // Largest count that the length field holds.
  localparam logic [CntW-1:0] CountCap = '1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCodingMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLen     = 2'd1;

  localparam logic CodingSix   = 1'b0;
  localparam logic CodingEight = 1'b1;

  // Six-bit special codes
  localparam logic [5:0] CodeLowShift = 6'h1B;
  localparam logic [5:0] CodeSymShift = 6'h1C;
  localparam logic [5:0] CodeBar      = 6'h1D;
  localparam logic [5:0] CodeUnder    = 6'h1E;
  localparam logic [5:0] CodeCaret    = 6'h1F;
  localparam logic [5:0] CodeLast     = 6'h2F;

  // Eight-bit special codes
  localparam logic [7:0] CodeEnd8 = 8'h00;

  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChAt    = 8'h40;

  typedef enum logic [2:0] {
    SH_NONE = 3'b001,
    SH_SYM  = 3'b010,
    SH_LOW  = 3'b100
  } shift_t;

  typedef struct packed {
    logic            coding_mode;
    logic [LimW-1:0] limit;       // characters allowed before the label ends
  } cfg_t;

  typedef struct packed {
    logic            char_valid;
    logic [7:0]      char_out;
    logic            label_done;
    logic [CntW-1:0] label_length;
  } res_t;

  function automatic logic [7:0] base_char(input logic [5:0] c);
    logic [7:0] ch;
    case (c) inside
      6'd0:            ch = 8'h20;
      [6'd1:6'd26]:    ch = 8'h40 + {2'b00, c};
      [6'd32:6'd41]:   ch = 8'h10 + {2'b00, c};
      default:         ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] c);
    logic [7:0] ch;
    case (c) inside
      6'd0:            ch = ChAt;
      [6'd1:6'd15]:    ch = 8'h20 + {2'b00, c};
      [6'd26:6'd31]:   ch = 8'h20 + {2'b00, c};
      [6'd43:6'd47]:   ch = 8'h30 + {2'b00, c};
      default:         ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] low_char(input logic [5:0] c);
    logic [7:0] ch;
    case (c) inside
      [6'd0:6'd26]:    ch = 8'h60 + {2'b00, c};
      default:         ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] map_char8(input logic [7:0] c);
    logic [7:0] ch;
    case (c) inside
      8'h1A:           ch = 8'h24;
      8'h1B:           ch = 8'h23;
      8'h1C:           ch = 8'h7E;
      8'h1D:           ch = ChBar;
      8'h1E:           ch = ChUnder;
      8'h1F:           ch = ChCaret;
      [8'h01:8'h06]:   ch = ChAt;
      default:         ch = c;
    endcase
    return ch;
  endfunction

endpackage

### design/lcd_in_if.sv
// ----------------------------------------------------------------------------
// lcd_in_if
// Code input channel: valid/ready handshake with one code per transfer.
// ----------------------------------------------------------------------------
interface lcd_in_if;
  logic                     valid;
  logic                     ready;
  logic [lcd_pkg::CodeW-1:0] code;
  logic                     end_of_data;

  modport source (output valid, output code, output end_of_data, input ready);
  modport sink   (input valid, input code, input end_of_data, output ready);
endinterface

### design/lcd_out_if.sv
// ----------------------------------------------------------------------------
// lcd_out_if
// Result channel: valid/ready handshake with one decoded result per transfer.
// ----------------------------------------------------------------------------
interface lcd_out_if;
  logic                     valid;
  logic                     ready;
  logic                     char_valid;
  logic [7:0]               char_out;
  logic                     label_done;
  logic [lcd_pkg::CntW-1:0] label_length;

  modport source (output valid, output char_valid, output char_out, output label_done,
                  output label_length, input ready);
  modport sink   (input valid, input char_valid, input char_out, input label_done,
                  input label_length, output ready);
endinterface

### design/lcd_cfg_if.sv
// ----------------------------------------------------------------------------
// lcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lcd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lcd_pkg::CfgIdxW-1:0] index;
  logic [lcd_pkg::MaxLenW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/lcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lcd_cfg_regs
// Configuration registers; the length limit is clamped when written.
// ----------------------------------------------------------------------------
module lcd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  lcd_cfg_if.sink        cfg,
  output lcd_pkg::cfg_t  cfg_q
);

  logic [lcd_pkg::LimW-1:0] limit_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (32'(cfg.data) > lcd_pkg::MAX_LABEL_LEN) begin
      limit_next = lcd_pkg::LimW'(lcd_pkg::MAX_LABEL_LEN - 1);
    end else if (cfg.data == '0) begin
      limit_next = '0;
    end else begin
      limit_next = lcd_pkg::LimW'(cfg.data - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.coding_mode <= lcd_pkg::CodingSix;
      cfg_q.limit       <= lcd_pkg::LimW'(lcd_pkg::MAX_LABEL_LEN - 1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lcd_pkg::CfgCodingMode: cfg_q.coding_mode <= cfg.data[0];
        lcd_pkg::CfgMaxLen:     cfg_q.limit       <= limit_next;
        default: ;
      endcase
    end
  end

endmodule

### design/lcd_decode.sv
// ----------------------------------------------------------------------------
// lcd_decode
// Per-code decode with the shift and character count state of one label.
// ----------------------------------------------------------------------------
module lcd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [lcd_pkg::CodeW-1:0] code,
  input  logic                      end_of_data,
  input  lcd_pkg::cfg_t             cfg_q,
  output lcd_pkg::res_t             res
);

  lcd_pkg::shift_t             shift_state, shift_next, shift_dec;
  logic [lcd_pkg::CntW-1:0]    char_count, char_count_next, count_inc;
  logic [5:0]                  c6;
  logic [7:0]                  base_ch;
  logic                        valid_dec, done_dec, at_limit;
  logic [7:0]                  ch_dec;

  assign c6        = code[5:0];
  assign base_ch   = lcd_pkg::base_char(c6);
  assign count_inc = char_count + 1'b1;
  assign at_limit  = (32'(count_inc) >= 32'(cfg_q.limit)) || (count_inc == lcd_pkg::CountCap);

  always_comb begin
    valid_dec = 1'b0;
    done_dec  = 1'b0;
    ch_dec    = 8'h00;
    shift_dec = shift_state;
    if (end_of_data) begin
      done_dec = 1'b1;
    end else if (cfg_q.coding_mode == lcd_pkg::CodingEight) begin
      shift_dec = lcd_pkg::SH_NONE;
      if (code == lcd_pkg::CodeEnd8) begin
        done_dec = 1'b1;
      end else begin
        ch_dec    = lcd_pkg::map_char8(code);
        valid_dec = 1'b1;
      end
    end else begin
      case (shift_state)
        lcd_pkg::SH_SYM: begin
          ch_dec    = lcd_pkg::sym_char(c6);
          valid_dec = 1'b1;
          shift_dec = lcd_pkg::SH_NONE;
        end
        lcd_pkg::SH_LOW: begin
          ch_dec    = lcd_pkg::low_char(c6);
          valid_dec = 1'b1;
          shift_dec = lcd_pkg::SH_NONE;
        end
        default: begin
          if (c6 > lcd_pkg::CodeLast) begin
            shift_dec = lcd_pkg::SH_NONE;
            done_dec  = 1'b1;
          end else if (base_ch != 8'h00) begin
            shift_dec = lcd_pkg::SH_NONE;
            ch_dec    = base_ch;
            valid_dec = 1'b1;
          end else if (c6 == lcd_pkg::CodeSymShift) begin
            shift_dec = lcd_pkg::SH_SYM;
          end else if (c6 == lcd_pkg::CodeLowShift) begin
            shift_dec = lcd_pkg::SH_LOW;
          end else begin
            // delimiters, and the '@' codes at the top of the table
            shift_dec = lcd_pkg::SH_NONE;
            valid_dec = 1'b1;
            case (c6)
              lcd_pkg::CodeBar:   ch_dec = lcd_pkg::ChBar;
              lcd_pkg::CodeUnder: ch_dec = lcd_pkg::ChUnder;
              lcd_pkg::CodeCaret: ch_dec = lcd_pkg::ChCaret;
              default:            ch_dec = lcd_pkg::ChAt;
            endcase
          end
        end
      endcase
    end
  end

  always_comb begin
    res.char_valid   = valid_dec;
    res.char_out     = ch_dec;
    res.label_done   = done_dec || (valid_dec && at_limit);
    res.label_length = valid_dec ? count_inc : char_count;
    if (res.label_done) begin
      shift_next      = lcd_pkg::SH_NONE;
      char_count_next = '0;
    end else begin
      shift_next      = shift_dec;
      char_count_next = res.label_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_state <= lcd_pkg::SH_NONE;
      char_count  <= '0;
    end else if (accept) begin
      shift_state <= shift_next;
      char_count  <= char_count_next;
    end
  end

`ifndef SYNTHESIS
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    accept && res.label_done |=> char_count == '0 && shift_state == lcd_pkg::SH_NONE)
    else $error("label end did not clear decoder state");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    accept && res.char_valid && !res.label_done |=> char_count == $past(res.label_length))
    else $error("character count does not follow reported length");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    !res.char_valid |-> res.char_out == 8'h00)
    else $error("character byte set without a character");

  a_shift_silent: assert property (@(posedge clk) disable iff (rst)
    accept && shift_next != lcd_pkg::SH_NONE |-> !res.char_valid && !res.label_done)
    else $error("shift code emitted a character or ended the label");
`endif

endmodule

### design/label_char_decoder.sv
// ----------------------------------------------------------------------------
// label_char_decoder
// Decodes six-bit shifted or eight-bit label codes, one a cycle unless out stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one code (plus end_of_data) per transfer. Every transfer yields
//         exactly one result on out, also for shift codes (char_valid low).
//   out : char_valid/char_out carry the decoded byte, label_done marks the
//         last result of a label, label_length counts characters so far.
//   cfg : register 0 selects the coding (0 six-bit, 1 eight-bit), register 1
//         sets the label limit; write only while no results are pending.
// Timing:
//   The decode is combinational from the input transfer and lands in a
//   single output register, on out the cycle after the transfer. One code
//   per cycle unless out stalls, as each code updates shift and count state.
//   in.ready stays high while the output register is empty or being taken.
// Reset clears the output valid flag, the pending shift and the count; cfg
// returns to six-bit coding and a 1023 character label limit. When out
// stalls, the held result stays put and in.ready drops until it is taken.
// ----------------------------------------------------------------------------
module label_char_decoder (
  input  logic       clk,
  input  logic       rst,
  lcd_in_if.sink     in,
  lcd_out_if.source  out,
  lcd_cfg_if.sink    cfg
);

  lcd_pkg::cfg_t cfg_q;
  lcd_pkg::res_t res, res_q;
  logic          out_valid;
  logic          accept;

  assign in.ready = !out_valid || out.ready;
  assign accept   = in.valid && in.ready;

  lcd_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  lcd_decode u_dec (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .code        (in.code),
    .end_of_data (in.end_of_data),
    .cfg_q       (cfg_q),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in.ready) begin
      out_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out.valid        = out_valid;
  assign out.char_valid   = res_q.char_valid;
  assign out.char_out     = res_q.char_out;
  assign out.label_done   = res_q.label_done;
  assign out.label_length = res_q.label_length;

endmodule
